@@ sv/cda_pkg.sv @@
`default_nettype none

package cda_pkg;

  // Operation codes carried in the operation word
  typedef enum logic [2:0] {
    OP_LOAD       = 3'd0,
    OP_SET_DAY    = 3'd1,
    OP_SET_MONTH  = 3'd2,
    OP_SET_YEAR   = 3'd3,
    OP_ADD_DAYS   = 3'd4,
    OP_ADD_MONTHS = 3'd5,
    OP_ADD_YEARS  = 3'd6
  } op_e;

  localparam logic [3:0] MONTH_JAN       = 4'd1;
  localparam logic [3:0] MONTH_DEC       = 4'd12;
  localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;
  localparam logic [4:0] DAY_FIRST       = 5'd1;
  localparam logic [4:0] DAY_LAST_DEC    = 5'd31;

  // Multiplicative inverse of 25 modulo 2^32 and the largest multiple image:
  // y is divisible by 25 exactly when y * INV25 (mod 2^32) <= LIM25.
  localparam logic [31:0] INV25 = 32'hC28F5C29;
  localparam logic [31:0] LIM25 = 32'h0A3D70A3;

  localparam logic [4:0] MONTH_LEN_COMMON [13] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };
  localparam logic [4:0] MONTH_LEN_LEAP [13] = '{
    5'd0, 5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic day_step;
    logic div_step;
    logic apply;
    logic clamp;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [2:0] op;
    logic       date_ok;
    logic       mag_zero;
  } sts_t;

  // Gregorian leap-year rule: by 4 and not by 100, or by 400
  function automatic logic is_leap(input logic [31:0] y);
    logic [31:0] prod;
    logic        div25;
    prod  = y * INV25;
    div25 = (prod <= LIM25);
    return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
  endfunction

  // Length of a month, zero for a month number outside 1..12
  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    if (m == 4'd0 || m > MONTHS_PER_YEAR) begin
      len = 5'd0;
    end else if (leap) begin
      len = MONTH_LEN_LEAP[m];
    end else begin
      len = MONTH_LEN_COMMON[m];
    end
    return len;
  endfunction

endpackage

`default_nettype wire

@@ sv/calendar_date_adjuster_top.sv @@
// A load or set word passes exec, then done; an add of years exec, apply and clamp; an add
// of months exec, a reciprocal divide by twelve, apply and clamp; an add of days exec and a
// day step per month boundary crossed, plus one when days remain after it.
// One word is taken at a time; busy is low again the cycle after the done_o strobe.
// The result is presented for one cycle on done_o; the receiver cannot stall.
// Reset clears the date to the invalid zero date; add words are refused until a load.
`default_nettype none

module calendar_date_adjuster_top #(
  parameter int YEAR_BITS   = 14,
  parameter int AMOUNT_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [2:0]             operation_i,
  input  wire logic [AMOUNT_BITS-1:0] amount_i,
  input  wire logic [4:0]             day_in_i,
  input  wire logic [3:0]             month_in_i,
  input  wire logic [YEAR_BITS-1:0]   year_in_i,
  output logic                        done_o,
  output logic [4:0]                  day_out_o,
  output logic [3:0]                  month_out_o,
  output logic [YEAR_BITS-1:0]        year_out_o,
  output logic                        rejected_o,
  output logic                        limited_o
);
  import cda_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cda_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  cda_datapath #(
    .YEAR_BITS   (YEAR_BITS),
    .AMOUNT_BITS (AMOUNT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .operation_i (operation_i),
    .amount_i    (amount_i),
    .day_in_i    (day_in_i),
    .month_in_i  (month_in_i),
    .year_in_i   (year_in_i),
    .day_o       (day_out_o),
    .month_o     (month_out_o),
    .year_o      (year_out_o),
    .rejected_o  (rejected_o),
    .limited_o   (limited_o)
  );

  // A limited result is never a refused one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && limited_o |-> !rejected_o)
    else $error("limited and rejected together");

  // A limited result is the floor date or the top date
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && limited_o |->
      (day_out_o == 5'd1 && month_out_o == 4'd1 && year_out_o == YEAR_BITS'(1)) ||
      (day_out_o == 5'd31 && month_out_o == 4'd12 && year_out_o == {YEAR_BITS{1'b1}}))
    else $error("limited date is neither floor nor top");

  // An accepted word always leaves a plausible date behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !rejected_o |->
      day_out_o != 5'd0 && month_out_o != 4'd0 && month_out_o <= 4'd12 &&
      year_out_o != '0)
    else $error("accepted word left an invalid date");

  // A taken word makes the block busy at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !done_o)
    else $error("word taken but block not busy");

  // The result strobe lasts a single cycle and frees the block next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire

@@ sv/cda_ctrl.sv @@
`default_nettype none

module cda_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  output logic               done_o,
  output cda_pkg::cmd_t      cmd_o,
  input  wire cda_pkg::sts_t sts_i
);
  import cda_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_DAYS  = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_APPLY = 7'b0010000,
    S_CLAMP = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Sequence the datapath through one word
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_DONE;
        if (sts_i.date_ok) begin
          unique case (sts_i.op)
            OP_ADD_DAYS:   state_d = S_DAYS;
            OP_ADD_MONTHS: state_d = S_DIV;
            OP_ADD_YEARS:  state_d = S_APPLY;
            default:       state_d = S_DONE;
          endcase
        end
      end
      S_DAYS: begin
        if (sts_i.mag_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.day_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d        = S_APPLY;
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = S_CLAMP;
      end
      S_CLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

`default_nettype wire

@@ sv/cda_datapath.sv @@
`default_nettype none

module cda_datapath #(
  parameter int YEAR_BITS   = 14,
  parameter int AMOUNT_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cda_pkg::cmd_t          cmd_i,
  output cda_pkg::sts_t               sts_o,
  input  wire logic [2:0]             operation_i,
  input  wire logic [AMOUNT_BITS-1:0] amount_i,
  input  wire logic [4:0]             day_in_i,
  input  wire logic [3:0]             month_in_i,
  input  wire logic [YEAR_BITS-1:0]   year_in_i,
  output logic [4:0]                  day_o,
  output logic [3:0]                  month_o,
  output logic [YEAR_BITS-1:0]        year_o,
  output logic                        rejected_o,
  output logic                        limited_o
);
  import cda_pkg::*;

  localparam int SW    = ((YEAR_BITS > AMOUNT_BITS) ? YEAR_BITS : AMOUNT_BITS) + 2;
  localparam int PW    = 2 * AMOUNT_BITS;
  localparam int RECIP_SHIFT = AMOUNT_BITS + 3;
  localparam logic [AMOUNT_BITS-1:0] RECIP12 =
    AMOUNT_BITS'(((1 << (AMOUNT_BITS + 1)) + 2) / 3);
  localparam logic [YEAR_BITS-1:0] YEAR_TOP   = {YEAR_BITS{1'b1}};
  localparam logic [YEAR_BITS-1:0] YEAR_FIRST = YEAR_BITS'(1);

  // Stored date and flags
  logic [4:0]             day_q, day_d;
  logic [3:0]             month_q, month_d;
  logic [YEAR_BITS-1:0]   year_q, year_d;
  logic                   rej_q, rej_d;
  logic                   lim_q, lim_d;

  // Latched word and working registers
  logic [2:0]             op_q, op_d;
  logic [4:0]             din_q, din_d;
  logic [3:0]             min_q, min_d;
  logic [YEAR_BITS-1:0]   yin_q, yin_d;
  logic                   neg_q, neg_d;
  logic [AMOUNT_BITS-1:0] mag_q, mag_d;
  logic [3:0]             rem_q, rem_d;

  // Candidate date for the validity check
  logic                   take_day, take_month, take_year;
  logic [4:0]             cand_day;
  logic [3:0]             cand_month;
  logic [YEAR_BITS-1:0]   cand_year;
  logic                   leap_c;
  logic [4:0]             dim_cand, dim_cur, dim_prev;
  logic                   date_ok;

  assign take_day   = (op_q == OP_LOAD) || (op_q == OP_SET_DAY);
  assign take_month = (op_q == OP_LOAD) || (op_q == OP_SET_MONTH);
  assign take_year  = (op_q == OP_LOAD) || (op_q == OP_SET_YEAR);
  assign cand_day   = take_day   ? din_q : day_q;
  assign cand_month = take_month ? min_q : month_q;
  assign cand_year  = take_year  ? yin_q : year_q;

  // One leap unit; during add work the candidate year is the stored year
  assign leap_c   = is_leap(32'(cand_year));
  assign dim_cand = days_in(cand_month, leap_c);
  assign dim_cur  = days_in(month_q, leap_c);
  assign dim_prev = days_in(month_q - 4'd1, leap_c);
  assign date_ok  = (cand_year != '0) && (cand_month >= MONTH_JAN) &&
                    (cand_month <= MONTH_DEC) && (cand_day >= DAY_FIRST) &&
                    (cand_day <= dim_cand);

  // Day stepping, one month boundary at most per cycle
  logic [4:0]             gap;
  logic                   fwd_fits, back_fits;
  assign gap       = dim_cur - day_q;
  assign fwd_fits  = (mag_q <= AMOUNT_BITS'(gap));
  assign back_fits = (mag_q < AMOUNT_BITS'(day_q));

  // Divide the magnitude by twelve with a reciprocal multiply
  logic [PW-1:0]          prod12;
  logic [AMOUNT_BITS-1:0] quot12;
  logic [3:0]             rem12;
  assign prod12 = PW'(mag_q) * PW'(RECIP12);
  assign quot12 = AMOUNT_BITS'(prod12 >> RECIP_SHIFT);
  assign rem12  = 4'(mag_q - (quot12 << 3) - (quot12 << 2));

  // Month and year application: quotient in mag_q, remainder in rem_q
  logic [4:0]             ms_fwd;
  logic                   carry, borrow;
  logic [3:0]             mn;
  logic [SW-1:0]          year_w, mag_w, yn;
  logic                   go_floor, go_top;

  assign ms_fwd = {1'b0, month_q} + {1'b0, rem_q};
  assign carry  = (ms_fwd > {1'b0, MONTH_DEC});
  assign borrow = (month_q <= rem_q);
  assign year_w = SW'(year_q);
  assign mag_w  = SW'(mag_q);

  always_comb begin
    if (neg_q) begin
      mn = borrow ? (month_q + MONTHS_PER_YEAR - rem_q) : (month_q - rem_q);
      yn = year_w - mag_w - SW'(borrow);
    end else begin
      mn = carry ? 4'(ms_fwd - {1'b0, MONTHS_PER_YEAR}) : ms_fwd[3:0];
      yn = year_w + mag_w + SW'(carry);
    end
  end

  assign go_floor = yn[SW-1] || (yn == '0);
  assign go_top   = !go_floor && (yn[SW-2:0] > (SW-1)'(YEAR_TOP));

  // Next-state of the datapath registers
  always_comb begin
    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    rej_d   = rej_q;
    lim_d   = lim_q;
    op_d    = op_q;
    din_d   = din_q;
    min_d   = min_q;
    yin_d   = yin_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    rem_d   = rem_q;

    if (cmd_i.latch) begin
      // capture the word and take the magnitude of the amount
      op_d  = operation_i;
      din_d = day_in_i;
      min_d = month_in_i;
      yin_d = year_in_i;
      neg_d = amount_i[AMOUNT_BITS-1];
      mag_d = amount_i[AMOUNT_BITS-1] ? (~amount_i + 1'b1) : amount_i;
      rem_d = '0;
      rej_d = 1'b0;
      lim_d = 1'b0;
    end else if (cmd_i.exec) begin
      // take a checked write, or refuse it and keep the old date; refuse an add on an invalid date or an unknown code
      unique case (op_q) inside
        OP_LOAD, OP_SET_DAY, OP_SET_MONTH, OP_SET_YEAR: begin
          if (date_ok) begin
            day_d   = cand_day;
            month_d = cand_month;
            year_d  = cand_year;
          end else begin
            rej_d = 1'b1;
          end
        end
        OP_ADD_DAYS, OP_ADD_MONTHS, OP_ADD_YEARS: begin
          if (!date_ok) begin
            rej_d = 1'b1;
          end
        end
        default: begin
          rej_d = 1'b1;
        end
      endcase
    end else if (cmd_i.day_step) begin
      if (!neg_q) begin
        // advance within the month, or to the first of the next, or stop at the top date
        if (fwd_fits) begin
          day_d = day_q + mag_q[4:0];
          mag_d = '0;
        end else begin
          mag_d = mag_q - AMOUNT_BITS'(gap) - 1'b1;
          day_d = DAY_FIRST;
          if (month_q == MONTH_DEC) begin
            if (year_q == YEAR_TOP) begin
              day_d   = DAY_LAST_DEC;
              month_d = MONTH_DEC;
              lim_d   = 1'b1;
              mag_d   = '0;
            end else begin
              month_d = MONTH_JAN;
              year_d  = year_q + 1'b1;
            end
          end else begin
            month_d = month_q + 4'd1;
          end
        end
      end else begin
        // go back within the month, or to the last day of the previous, or stop at the floor date
        if (back_fits) begin
          day_d = day_q - mag_q[4:0];
          mag_d = '0;
        end else begin
          mag_d = mag_q - AMOUNT_BITS'(day_q);
          if (month_q == MONTH_JAN) begin
            if (year_q == YEAR_FIRST) begin
              day_d = DAY_FIRST;
              lim_d = 1'b1;
              mag_d = '0;
            end else begin
              month_d = MONTH_DEC;
              year_d  = year_q - 1'b1;
              day_d   = DAY_LAST_DEC;
            end
          end else begin
            month_d = month_q - 4'd1;
            day_d   = dim_prev;
          end
        end
      end
    end else if (cmd_i.div_step) begin
      // split the magnitude into whole years and leftover months
      rem_d = rem12;
      mag_d = quot12;
    end else if (cmd_i.apply) begin
      // floor or saturate out-of-range years, otherwise move the date
      if (go_floor) begin
        day_d   = DAY_FIRST;
        month_d = MONTH_JAN;
        year_d  = YEAR_FIRST;
        lim_d   = 1'b1;
      end else if (go_top) begin
        day_d   = DAY_LAST_DEC;
        month_d = MONTH_DEC;
        year_d  = YEAR_TOP;
        lim_d   = 1'b1;
      end else begin
        month_d = mn;
        year_d  = yn[YEAR_BITS-1:0];
      end
    end else if (cmd_i.clamp) begin
      // hold the day within the length of the new month
      if (day_q > dim_cur) begin
        day_d = dim_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_q   <= '0;
      month_q <= '0;
      year_q  <= '0;
      rej_q   <= 1'b0;
      lim_q   <= 1'b0;
    end else begin
      day_q   <= day_d;
      month_q <= month_d;
      year_q  <= year_d;
      rej_q   <= rej_d;
      lim_q   <= lim_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    din_q <= din_d;
    min_q <= min_d;
    yin_q <= yin_d;
    neg_q <= neg_d;
    mag_q <= mag_d;
    rem_q <= rem_d;
  end

  assign sts_o.op       = op_q;
  assign sts_o.date_ok  = date_ok;
  assign sts_o.mag_zero = (mag_q == '0);

  assign day_o      = day_q;
  assign month_o    = month_q;
  assign year_o     = year_q;
  assign rejected_o = rej_q;
  assign limited_o  = lim_q;

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import cda_pkg::*;

  localparam int YEAR_W      = 14;
  localparam int AMOUNT_W    = 16;
  localparam int YEAR_TOP    = (1 << YEAR_W) - 1;
  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int DRAIN_WAIT  = 64;

  // Operation code outside the defined set
  localparam logic [2:0] OP_UNKNOWN = 3'd7;

  typedef struct packed {
    logic [4:0]        day;
    logic [3:0]        month;
    logic [YEAR_W-1:0] year;
    logic              rejected;
    logic              limited;
  } date_result_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic [2:0]          operation_i = '0;
  logic [AMOUNT_W-1:0] amount_i    = '0;
  logic [4:0]          day_in_i    = '0;
  logic [3:0]          month_in_i  = '0;
  logic [YEAR_W-1:0]   year_in_i   = '0;
  logic                busy;
  logic                done_o;
  logic [4:0]          day_out_o;
  logic [3:0]          month_out_o;
  logic [YEAR_W-1:0]   year_out_o;
  logic                rejected_o;
  logic                limited_o;

  // Shadow date, cleared like the block's own register
  int cur_day   = 0;
  int cur_month = 0;
  int cur_year  = 0;

  date_result_t pending_dates[$];
  int           mismatch_count  = 0;
  int           cycle_count     = 0;
  int           sender_idle_pct = 0;

  calendar_date_adjuster_top #(
    .YEAR_BITS  (YEAR_W),
    .AMOUNT_BITS(AMOUNT_W)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .operation_i(operation_i),
    .amount_i   (amount_i),
    .day_in_i   (day_in_i),
    .month_in_i (month_in_i),
    .year_in_i  (year_in_i),
    .done_o     (done_o),
    .day_out_o  (day_out_o),
    .month_out_o(month_out_o),
    .year_out_o (year_out_o),
    .rejected_o (rejected_o),
    .limited_o  (limited_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Calendar arithmetic of the shadow date
  // ---------------------------------------------------------------------------

  function automatic bit leap_year(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_len(input int m, input int y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic bit date_valid(input int d, input int m, input int y);
    return y >= 1 && y <= YEAR_TOP && m >= 1 && m <= 12 && d >= 1 && d <= month_len(m, y);
  endfunction

  function automatic void floor_date();
    cur_day   = 1;
    cur_month = 1;
    cur_year  = 1;
  endfunction

  function automatic void saturate_date();
    cur_day   = 31;
    cur_month = 12;
    cur_year  = YEAR_TOP;
  endfunction

  function automatic void clamp_to_month();
    if (cur_day > month_len(cur_month, cur_year)) cur_day = month_len(cur_month, cur_year);
  endfunction

  // Step a whole month at a time where the count allows; return 1 when limited
  function automatic bit roll_days(input int n);
    int span;
    while (n > 0) begin
      span = month_len(cur_month, cur_year) - cur_day;
      if (n <= span) begin
        cur_day += n;
        n = 0;
      end else begin
        n -= span + 1;
        cur_day = 1;
        cur_month++;
        if (cur_month > 12) begin
          cur_month = 1;
          if (cur_year >= YEAR_TOP) begin
            saturate_date();
            return 1'b1;
          end
          cur_year++;
        end
      end
    end
    while (n < 0) begin
      if (-n < cur_day) begin
        cur_day += n;
        n = 0;
      end else begin
        n += cur_day;
        cur_month--;
        if (cur_month == 0) begin
          cur_month = 12;
          if (cur_year <= 1) begin
            floor_date();
            return 1'b1;
          end
          cur_year--;
        end
        cur_day = month_len(cur_month, cur_year);
      end
    end
    return 1'b0;
  endfunction

  function automatic bit roll_months(input int n);
    int total;
    total = cur_year * 12 + (cur_month - 1) + n;
    if (total < 12) begin
      floor_date();
      return 1'b1;
    end
    if (total / 12 > YEAR_TOP) begin
      saturate_date();
      return 1'b1;
    end
    cur_year  = total / 12;
    cur_month = total % 12 + 1;
    clamp_to_month();
    return 1'b0;
  endfunction

  function automatic bit roll_years(input int n);
    int y;
    y = cur_year + n;
    if (y <= 0) begin
      floor_date();
      return 1'b1;
    end
    if (y > YEAR_TOP) begin
      saturate_date();
      return 1'b1;
    end
    cur_year = y;
    clamp_to_month();
    return 1'b0;
  endfunction

  // Apply one accepted word to the shadow date and queue the date it must report
  function automatic void apply_date_word(input logic [2:0] op,
                                          input logic [AMOUNT_W-1:0] amt_bits,
                                          input logic [4:0] d_in,
                                          input logic [3:0] m_in,
                                          input logic [YEAR_W-1:0] y_in);
    int           n;
    int           d;
    int           m;
    int           y;
    bit           rej;
    bit           lim;
    date_result_t res;
    n   = int'($signed(amt_bits));
    d   = int'(d_in);
    m   = int'(m_in);
    y   = int'(y_in);
    rej = 1'b0;
    lim = 1'b0;
    case (op)
      OP_LOAD: begin
        if (date_valid(d, m, y)) begin
          cur_day   = d;
          cur_month = m;
          cur_year  = y;
        end else begin
          rej = 1'b1;
        end
      end
      OP_SET_DAY: begin
        if (date_valid(d, cur_month, cur_year)) cur_day = d;
        else rej = 1'b1;
      end
      OP_SET_MONTH: begin
        if (date_valid(cur_day, m, cur_year)) cur_month = m;
        else rej = 1'b1;
      end
      OP_SET_YEAR: begin
        if (date_valid(cur_day, cur_month, y)) cur_year = y;
        else rej = 1'b1;
      end
      OP_ADD_DAYS, OP_ADD_MONTHS, OP_ADD_YEARS: begin
        if (!date_valid(cur_day, cur_month, cur_year)) rej = 1'b1;
        else if (op == OP_ADD_DAYS) lim = roll_days(n);
        else if (op == OP_ADD_MONTHS) lim = roll_months(n);
        else lim = roll_years(n);
      end
      default: rej = 1'b1;
    endcase
    res.day      = cur_day[4:0];
    res.month    = cur_month[3:0];
    res.year     = cur_year[YEAR_W-1:0];
    res.rejected = rej;
    res.limited  = lim;
    pending_dates.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------
  // Word sender and result checker
  // ---------------------------------------------------------------------------

  // Idle at random, present one word and hold it until the block takes it
  task automatic issue_word(input logic [2:0] op, input int amt, input int d, input int m,
                            input int y);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start       <= 1'b1;
    operation_i <= op;
    amount_i    <= amt[AMOUNT_W-1:0];
    day_in_i    <= d[4:0];
    month_in_i  <= m[3:0];
    year_in_i   <= y[YEAR_W-1:0];
    do @(posedge clk_i); while (busy !== 1'b0);
    apply_date_word(op, amt[AMOUNT_W-1:0], d[4:0], m[3:0], y[YEAR_W-1:0]);
  endtask

  // Compare each strobed result with the oldest expected date
  always @(posedge clk_i) begin
    date_result_t exp_res;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_dates.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result %0d/%0d/%0d rej %0b lim %0b", day_out_o,
                   month_out_o, year_out_o, rejected_o, limited_o);
        mismatch_count++;
      end else begin
        exp_res = pending_dates.pop_front();
        if (day_out_o !== exp_res.day || month_out_o !== exp_res.month ||
            year_out_o !== exp_res.year || rejected_o !== exp_res.rejected ||
            limited_o !== exp_res.limited) begin
          if (mismatch_count < 10)
            $display("date mismatch: exp %0d/%0d/%0d rej %0b lim %0b, got %0d/%0d/%0d rej %0b lim %0b",
                     exp_res.day, exp_res.month, exp_res.year, exp_res.rejected,
                     exp_res.limited, day_out_o, month_out_o, year_out_o, rejected_o,
                     limited_o);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Adds, day and year sets and an unknown code against the zero date left by reset
  task automatic test_reset_date();
    issue_word(OP_ADD_DAYS, 1, 0, 0, 0);
    issue_word(OP_ADD_MONTHS, -1, 0, 0, 0);
    issue_word(OP_ADD_YEARS, 0, 0, 0, 0);
    issue_word(OP_SET_DAY, 0, 1, 0, 0);
    issue_word(OP_SET_YEAR, 0, 0, 0, 2000);
    issue_word(OP_UNKNOWN, 0, 0, 0, 0);
  endtask

  // Checked loads and sets, including leap days and short months, and an unknown code
  task automatic test_checked_writes();
    issue_word(OP_LOAD, 0, 31, 15, YEAR_TOP);
    issue_word(OP_LOAD, 0, 29, 2, 1900);
    issue_word(OP_LOAD, 0, 29, 2, 2000);
    issue_word(OP_SET_DAY, 0, 31, 0, 0);
    issue_word(OP_SET_MONTH, 0, 0, 15, 0);
    issue_word(OP_SET_YEAR, 0, 0, 0, 1999);
    issue_word(OP_SET_YEAR, 0, 0, 0, 2400);
    issue_word(OP_LOAD, 0, 31, 1, 2023);
    issue_word(OP_SET_MONTH, 0, 0, 4, 0);
    issue_word(OP_SET_MONTH, 0, 0, 12, 0);
    issue_word(OP_UNKNOWN, -1, 31, 15, YEAR_TOP);
  endtask

  // Floor at 1/1/1, saturation at the top year, clamping and December wrap
  task automatic test_limits();
    issue_word(OP_LOAD, 0, 1, 1, 1);
    issue_word(OP_ADD_DAYS, -1, 0, 0, 0);
    issue_word(OP_ADD_MONTHS, -1, 0, 0, 0);
    issue_word(OP_ADD_YEARS, -32768, 0, 0, 0);
    issue_word(OP_LOAD, 0, 31, 12, YEAR_TOP);
    issue_word(OP_ADD_DAYS, 1, 0, 0, 0);
    issue_word(OP_ADD_MONTHS, 32767, 0, 0, 0);
    issue_word(OP_ADD_YEARS, 1, 0, 0, 0);
    issue_word(OP_LOAD, 0, 31, 1, 2024);
    issue_word(OP_ADD_MONTHS, 1, 0, 0, 0);
    issue_word(OP_ADD_YEARS, 1, 0, 0, 0);
    issue_word(OP_LOAD, 0, 31, 12, 1999);
    issue_word(OP_ADD_DAYS, 1, 0, 0, 0);
    issue_word(OP_ADD_DAYS, 0, 0, 0, 0);
    issue_word(OP_ADD_DAYS, -32768, 0, 0, 0);
  endtask

  // Years cluster at both ends of the range and around the century leap rules
  function automatic int pick_year();
    int r;
    r = $urandom_range(99);
    if (r < 15) return $urandom_range(3, 1);
    if (r < 30) return $urandom_range(YEAR_TOP, YEAR_TOP - 3);
    if (r < 45) return $urandom_range(YEAR_TOP, 1);
    return $urandom_range(2110, 1890);
  endfunction

  function automatic int pick_amount(input int span);
    int mag;
    mag = $urandom_range(span, 0);
    return ($urandom_range(1) != 0) ? -mag : mag;
  endfunction

  // Mostly adds among valid loads; some noise loads, sets that may fail and bad codes
  task automatic test_random_words(input int count, input int idle_pct);
    int         r;
    int         s;
    int         d;
    int         m;
    int         y;
    int         amt;
    logic [2:0] op;
    sender_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      r   = $urandom_range(99);
      y   = pick_year();
      m   = $urandom_range(12, 1);
      d   = ($urandom_range(3) == 0) ? month_len(m, y) : $urandom_range(month_len(m, y), 1);
      amt = int'($urandom_range(65535)) - 32768;
      s   = $urandom_range(99);
      if (r < 10) begin
        op = OP_LOAD;
      end else if (r < 15) begin
        op = OP_LOAD;
        d  = $urandom_range(31);
        m  = $urandom_range(15);
        y  = $urandom_range(YEAR_TOP);
      end else if (r < 20) begin
        op = OP_SET_DAY;
        d  = $urandom_range(31, 1);
      end else if (r < 25) begin
        op = OP_SET_MONTH;
        m  = $urandom_range(15);
      end else if (r < 30) begin
        op = OP_SET_YEAR;
      end else if (r < 55) begin
        op = OP_ADD_DAYS;
        if (s < 55) amt = pick_amount(62);
        else if (s < 85) amt = pick_amount(1500);
        else if (s < 97) amt = pick_amount(8000);
      end else if (r < 75) begin
        op = OP_ADD_MONTHS;
        if (s < 70) amt = pick_amount(40);
      end else if (r < 97) begin
        op = OP_ADD_YEARS;
        if (s < 60) amt = pick_amount(20);
      end else begin
        op = OP_UNKNOWN;
      end
      issue_word(op, amt, d, m, y);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 35;
    test_reset_date();
    test_checked_writes();
    test_limits();
    test_random_words(470, 35);
    test_random_words(470, 73);
    test_random_words(470, 0);
    start <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatch_count == 0 && pending_dates.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/cda_pkg.sv
sv/cda_ctrl.sv
sv/cda_datapath.sv
sv/calendar_date_adjuster_top.sv
bench/tb_top.sv
